/* rtl/ldiff_pkg.sv */
`timescale 1ns / 1ps
package ldiff_pkg;

  localparam int SMP_W   = 32;               // Q16.16 samples and rhs
  localparam int DIFF_W  = SMP_W + 1;        // difference of two samples
  localparam int FLUX_W  = DIFF_W + 5;       // 10,-5,1 weighted sum
  localparam int DELTA_W = FLUX_W + 1;       // high minus low flux
  localparam int MAG_W   = DELTA_W - 1;      // magnitude of the difference
  localparam int MAG_LO  = MAG_W / 2;        // low slice of the magnitude split
  localparam int FAC_W   = 16;               // Q2.14 map factor
  localparam int M15_W   = FAC_W + 1;        // Q2.15 combined map factor
  localparam int GAIN_W  = 32;               // Q8.24 gain
  localparam int P_W     = 55;               // magnitude times map factor
  localparam int P_LO    = 28;               // low slice of that product
  localparam int WR_W    = P_W + GAIN_W + 1; // full product plus rounding carry
  localparam int RND_SH  = 39;               // Q.55 down to Q16.16
  localparam int Q_W     = WR_W - RND_SH;
  localparam int QC_W    = 41;               // clamped magnitude, up to 2^40
  localparam int TERM_W  = QC_W + 1;
  localparam int SUM_W   = TERM_W + 1;

  localparam logic [M15_W-1:0] ONE_Q15 = M15_W'(32768);

  localparam logic [1:0] KIND_X = 2'd0;
  localparam logic [1:0] KIND_Y = 2'd1;

  localparam logic [1:0] CFG_GAIN  = 2'd0;
  localparam logic [1:0] CFG_AVG_X = 2'd1;
  localparam logic [1:0] CFG_AVG_Y = 2'd2;

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [SMP_W-1:0] sm3;
    logic signed [SMP_W-1:0] sm2;
    logic signed [SMP_W-1:0] sm1;
    logic signed [SMP_W-1:0] s0;
    logic signed [SMP_W-1:0] sp1;
    logic signed [SMP_W-1:0] sp2;
    logic signed [SMP_W-1:0] sp3;
    logic [FAC_W-1:0]        fh;
    logic [FAC_W-1:0]        fn;
    logic signed [SMP_W-1:0] rhs;
  } win_t;

  typedef struct packed {
    logic                    neg;
    logic [MAG_W-1:0]        mag;
    logic [M15_W-1:0]        m15;
    logic signed [SMP_W-1:0] rhs;
  } flux_t;

  typedef struct packed {
    logic                    neg;
    logic [WR_W-1:0]         wr;
    logic signed [SMP_W-1:0] rhs;
  } scaled_t;

endpackage

/* rtl/ldiff_flux.sv */
`timescale 1ns / 1ps
module ldiff_flux (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           avg_x,
  input  logic           avg_y,
  input  logic           in_valid,
  output logic           in_ready,
  input  ldiff_pkg::win_t in_win,
  output logic           out_valid,
  input  logic           out_ready,
  output ldiff_pkg::flux_t out_flux
);
  import ldiff_pkg::*;

  // fifth-difference flux; zero it when it opposes the first difference
  function automatic logic signed [FLUX_W-1:0] lim_flux(
    input logic signed [DIFF_W-1:0] d1,
    input logic signed [DIFF_W-1:0] d2,
    input logic signed [DIFF_W-1:0] d3
  );
    logic signed [FLUX_W-1:0] e1;
    logic signed [FLUX_W-1:0] e2;
    logic signed [FLUX_W-1:0] e3;
    logic signed [FLUX_W-1:0] f;
    e1 = FLUX_W'(d1);
    e2 = FLUX_W'(d2);
    e3 = FLUX_W'(d3);
    f  = (e1 <<< 3) + (e1 <<< 1) - (e2 <<< 2) - e2 + e3;
    if ((f != '0) && (d1 != '0) && (f[FLUX_W-1] != d1[DIFF_W-1])) begin
      f = '0;
    end
    return f;
  endfunction

  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;

  logic signed [DIFF_W-1:0] lo_d1_r, lo_d2_r, lo_d3_r;
  logic signed [DIFF_W-1:0] hi_d1_r, hi_d2_r, hi_d3_r;
  logic [M15_W-1:0]         m15_1_r, m15_2_r, m15_nxt;
  logic signed [SMP_W-1:0]  rhs_1_r, rhs_2_r;
  logic signed [FLUX_W-1:0] lo_r, hi_r;
  flux_t                    flux_r, flux_nxt;
  logic signed [DELTA_W-1:0] dpos, dneg;

  assign en3      = !v3_r || out_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;
  assign out_valid = v3_r;
  assign out_flux  = flux_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_comb begin
    unique case (in_win.kind)
      KIND_X:  m15_nxt = avg_x ? (M15_W'(in_win.fh) + M15_W'(in_win.fn))
                               : {in_win.fh, 1'b0};
      KIND_Y:  m15_nxt = avg_y ? (M15_W'(in_win.fh) + M15_W'(in_win.fn))
                               : {in_win.fh, 1'b0};
      default: m15_nxt = ONE_Q15;
    endcase
  end

  assign dpos = DELTA_W'(hi_r) - DELTA_W'(lo_r);
  assign dneg = DELTA_W'(lo_r) - DELTA_W'(hi_r);

  always_comb begin
    flux_nxt.neg = dpos[DELTA_W-1];
    flux_nxt.mag = dpos[DELTA_W-1] ? dneg[MAG_W-1:0] : dpos[MAG_W-1:0];
    flux_nxt.m15 = m15_2_r;
    flux_nxt.rhs = rhs_2_r;
  end

  always_ff @(posedge clk) begin
    // first differences of both faces
    if (en1 && in_valid) begin
      lo_d1_r <= DIFF_W'(in_win.s0)  - DIFF_W'(in_win.sm1);
      lo_d2_r <= DIFF_W'(in_win.sp1) - DIFF_W'(in_win.sm2);
      lo_d3_r <= DIFF_W'(in_win.sp2) - DIFF_W'(in_win.sm3);
      hi_d1_r <= DIFF_W'(in_win.sp1) - DIFF_W'(in_win.s0);
      hi_d2_r <= DIFF_W'(in_win.sp2) - DIFF_W'(in_win.sm1);
      hi_d3_r <= DIFF_W'(in_win.sp3) - DIFF_W'(in_win.sm2);
      m15_1_r <= m15_nxt;
      rhs_1_r <= in_win.rhs;
    end
    if (en2 && v1_r) begin
      lo_r    <= lim_flux(lo_d1_r, lo_d2_r, lo_d3_r);
      hi_r    <= lim_flux(hi_d1_r, hi_d2_r, hi_d3_r);
      m15_2_r <= m15_1_r;
      rhs_2_r <= rhs_1_r;
    end
    if (en3 && v2_r) begin
      flux_r <= flux_nxt;
    end
  end

endmodule

/* rtl/ldiff_scale.sv */
`timescale 1ns / 1ps
module ldiff_scale (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [ldiff_pkg::GAIN_W-1:0] gain,
  input  logic               in_valid,
  output logic               in_ready,
  input  ldiff_pkg::flux_t   in_flux,
  output logic               out_valid,
  input  logic               out_ready,
  output ldiff_pkg::scaled_t out_scaled
);
  import ldiff_pkg::*;

  localparam int MAG_HI = MAG_W - MAG_LO;
  localparam int PM_LO  = MAG_LO + M15_W;
  localparam int PM_HI  = MAG_HI + M15_W;
  localparam int PG_LO  = P_LO + GAIN_W;
  localparam int PG_HI  = P_W - P_LO + GAIN_W;
  localparam logic [WR_W-1:0] ROUND = WR_W'(1) << (RND_SH - 1);

  logic v4_r, v5_r, v6_r, v7_r;
  logic en4, en5, en6, en7;

  logic [PM_LO-1:0]        pm_lo_r;
  logic [PM_HI-1:0]        pm_hi_r;
  logic [P_W-1:0]          p_r, p_nxt;
  logic [PG_LO-1:0]        pg_lo_r;
  logic [PG_HI-1:0]        pg_hi_r;
  logic [WR_W-1:0]         wr_nxt;
  logic                    neg4_r, neg5_r, neg6_r;
  logic signed [SMP_W-1:0] rhs4_r, rhs5_r, rhs6_r;
  scaled_t                 sc_r;

  assign en7 = !v7_r || out_ready;
  assign en6 = !v6_r || en7;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign in_ready   = en4;
  assign out_valid  = v7_r;
  assign out_scaled = sc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      if (en4) v4_r <= in_valid;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
      if (en7) v7_r <= v6_r;
    end
  end

  assign p_nxt  = (P_W'(pm_hi_r) << MAG_LO) + P_W'(pm_lo_r);
  assign wr_nxt = (WR_W'(pg_hi_r) << P_LO) + WR_W'(pg_lo_r) + ROUND;

  always_ff @(posedge clk) begin
    // split magnitude times map factor
    if (en4 && in_valid) begin
      pm_lo_r <= PM_LO'(in_flux.mag[MAG_LO-1:0] * in_flux.m15);
      pm_hi_r <= PM_HI'(in_flux.mag[MAG_W-1:MAG_LO] * in_flux.m15);
      neg4_r  <= in_flux.neg;
      rhs4_r  <= in_flux.rhs;
    end
    if (en5 && v4_r) begin
      p_r    <= p_nxt;
      neg5_r <= neg4_r;
      rhs5_r <= rhs4_r;
    end
    // split product times gain
    if (en6 && v5_r) begin
      pg_lo_r <= PG_LO'(p_r[P_LO-1:0] * gain);
      pg_hi_r <= PG_HI'(p_r[P_W-1:P_LO] * gain);
      neg6_r  <= neg5_r;
      rhs6_r  <= rhs5_r;
    end
    // recombine and add the half-LSB for round to nearest
    if (en7 && v6_r) begin
      sc_r.wr  <= wr_nxt;
      sc_r.neg <= neg6_r;
      sc_r.rhs <= rhs6_r;
    end
  end

endmodule

/* rtl/limited_sixth_order_diffusion_core.sv */
`timescale 1ns / 1ps
// Channel  Direction  Handshake                  Payload
// in_      input      in_valid / in_ready        kind, seven samples, two map factors, rhs_in
// out_     output     out_valid / out_ready      rhs_out
// cfg_     input      cfg_we (no wait)           cfg_index, cfg_wdata
//
// One request per cycle sustained while out_ready stays high; a request passes
// from acceptance to out_valid through the nine register stages of the path
// (flux, two split multiplies, rounding, clamp, saturating add).
// Reset is synchronous, active low; it clears every stage valid and the
// configuration registers. A stall on out_ready holds only the occupied
// stages; empty stages ahead still fill, so in_ready drops only when the
// whole pipe is full.
module limited_sixth_order_diffusion_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic signed [31:0] in_sample_minus3,
  input  logic signed [31:0] in_sample_minus2,
  input  logic signed [31:0] in_sample_minus1,
  input  logic signed [31:0] in_sample_center,
  input  logic signed [31:0] in_sample_plus1,
  input  logic signed [31:0] in_sample_plus2,
  input  logic signed [31:0] in_sample_plus3,
  input  logic [15:0] in_factor_here,
  input  logic [15:0] in_factor_neighbour,
  input  logic signed [31:0] in_rhs_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_rhs_out
);
  import ldiff_pkg::*;

  localparam logic [Q_W-1:0] Q_CAP = Q_W'(1) << (QC_W - 1);
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(32'sh7FFF_FFFF);
  localparam logic signed [SUM_W-1:0] SUM_MIN = -(SUM_W'(1) << (SMP_W - 1));

  // configuration
  logic [GAIN_W-1:0] gain_r;
  logic              avg_x_r, avg_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= '0;
      avg_x_r <= 1'b0;
      avg_y_r <= 1'b0;
    end else if (cfg_we) begin
      // indexes beyond the list fall through and are dropped
      unique case (cfg_index)
        CFG_GAIN:  gain_r  <= cfg_wdata;
        CFG_AVG_X: avg_x_r <= cfg_wdata[0];
        CFG_AVG_Y: avg_y_r <= cfg_wdata[0];
        default:   ;
      endcase
    end
  end

  // pack the window
  win_t win;
  always_comb begin
    win.kind = in_kind;
    win.sm3  = in_sample_minus3;
    win.sm2  = in_sample_minus2;
    win.sm1  = in_sample_minus1;
    win.s0   = in_sample_center;
    win.sp1  = in_sample_plus1;
    win.sp2  = in_sample_plus2;
    win.sp3  = in_sample_plus3;
    win.fh   = in_factor_here;
    win.fn   = in_factor_neighbour;
    win.rhs  = in_rhs_in;
  end

  // stages 1-3: differences, limited fluxes, signed magnitude
  logic  fx_valid, fx_ready;
  flux_t fx;

  ldiff_flux u_flux (
    .clk       (clk),
    .rst_n     (rst_n),
    .avg_x     (avg_x_r),
    .avg_y     (avg_y_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_win    (win),
    .out_valid (fx_valid),
    .out_ready (fx_ready),
    .out_flux  (fx)
  );

  // stages 4-7: map factor and gain products, rounding
  logic    sc_valid, sc_ready;
  scaled_t sc;

  ldiff_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .gain       (gain_r),
    .in_valid   (fx_valid),
    .in_ready   (fx_ready),
    .in_flux    (fx),
    .out_valid  (sc_valid),
    .out_ready  (sc_ready),
    .out_scaled (sc)
  );

  // stage 8: drop the fraction, clamp, apply the sign
  // stage 9: add to rhs and saturate into the output register
  logic v8_r, vo_r;
  logic en8, eno;
  logic [Q_W-1:0]          q;
  logic [QC_W-1:0]         qc;
  logic signed [TERM_W-1:0] term_r, term_nxt;
  logic signed [SMP_W-1:0]  rhs8_r;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SMP_W-1:0]  rhs_out_r, rhs_out_nxt;

  assign eno      = !vo_r || out_ready;
  assign en8      = !v8_r || eno;
  assign sc_ready = en8;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (en8) v8_r <= sc_valid;
      if (eno) vo_r <= v8_r;
    end
  end

  assign q  = sc.wr[WR_W-1:RND_SH];
  assign qc = (q > Q_CAP) ? Q_CAP[QC_W-1:0] : q[QC_W-1:0];
  assign term_nxt = sc.neg ? (TERM_W'(0) - TERM_W'({1'b0, qc})) : TERM_W'({1'b0, qc});

  assign sum = SUM_W'(rhs8_r) + SUM_W'(term_r);

  always_comb begin
    priority if (sum > SUM_MAX) begin
      rhs_out_nxt = SMP_W'(SUM_MAX);
    end else if (sum < SUM_MIN) begin
      rhs_out_nxt = SMP_W'(SUM_MIN);
    end else begin
      rhs_out_nxt = sum[SMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en8 && sc_valid) begin
      term_r <= term_nxt;
      rhs8_r <= sc.rhs;
    end
    if (eno && v8_r) begin
      rhs_out_r <= rhs_out_nxt;
    end
  end

  assign out_valid   = vo_r;
  assign out_rhs_out = rhs_out_r;

endmodule

/* sim/limited_diffusion_checker.sv */
`timescale 1ns / 1ps
module limited_diffusion_checker
  import ldiff_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  win_t               in_window,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_rhs_out,
  output int                 fail_count,
  output int                 pending,
  output int                 checked
);

  localparam longint RHS_MAX = 64'sd2147483647;
  localparam longint RHS_MIN = -64'sd2147483648;
  localparam logic [127:0] ROUND_HALF = 128'd1 << 38;
  localparam logic [127:0] TERM_CAP = 128'd1 << 40;

  logic [31:0]        gain_q824;
  logic               avg_x;
  logic               avg_y;
  logic signed [31:0] rhs_expect_q[$];
  logic signed [31:0] rhs_expected;

  // fifth-difference flux across one face, dropped when it opposes the local slope
  function automatic longint capped_flux(input longint a, b, c, d, e, f);
    longint slope;
    longint flux;
    slope = d - c;
    flux = 10 * (d - c) - 5 * (e - b) + (f - a);
    if ((flux > 0 && slope < 0) || (flux < 0 && slope > 0)) flux = 0;
    return flux;
  endfunction

  function automatic logic signed [31:0] predict_rhs(input win_t w);
    longint       lo_flux;
    longint       hi_flux;
    longint       delta;
    longint       term;
    longint       total;
    logic [16:0]  m15;
    logic [127:0] mag;
    logic [127:0] scaled;
    lo_flux = capped_flux(w.sm3, w.sm2, w.sm1, w.s0, w.sp1, w.sp2);
    hi_flux = capped_flux(w.sm2, w.sm1, w.s0, w.sp1, w.sp2, w.sp3);
    delta = hi_flux - lo_flux;
    case (w.kind)
      KIND_X:  m15 = avg_x ? {1'b0, w.fh} + {1'b0, w.fn} : {w.fh, 1'b0};
      KIND_Y:  m15 = avg_y ? {1'b0, w.fh} + {1'b0, w.fn} : {w.fh, 1'b0};
      default: m15 = ONE_Q15;
    endcase
    mag = 128'((delta < 0) ? -delta : delta);
    // Q.55 product, rounded half away from zero down to Q16.16
    scaled = (mag * m15 * gain_q824 + ROUND_HALF) >> 39;
    if (scaled > TERM_CAP) scaled = TERM_CAP;
    term = longint'(scaled[40:0]);
    if (delta < 0) term = -term;
    total = longint'(w.rhs) + term;
    if (total > RHS_MAX) total = RHS_MAX;
    if (total < RHS_MIN) total = RHS_MIN;
    return total[31:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      gain_q824 = '0;
      avg_x = 1'b0;
      avg_y = 1'b0;
      rhs_expect_q.delete();
      pending = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GAIN:  gain_q824 = cfg_wdata;
          CFG_AVG_X: avg_x = cfg_wdata[0];
          CFG_AVG_Y: avg_y = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) rhs_expect_q.push_back(predict_rhs(in_window));
      if (out_valid && out_ready) begin
        if (rhs_expect_q.size() == 0) begin
          $error("rhs_out: expected none, actual %0d", out_rhs_out);
          fail_count++;
        end else begin
          rhs_expected = rhs_expect_q.pop_front();
          checked++;
          if (out_rhs_out !== rhs_expected) begin
            $error("rhs_out: expected %0d, actual %0d", rhs_expected, out_rhs_out);
            fail_count++;
          end
        end
      end
      pending = rhs_expect_q.size();
    end
  end

endmodule

/* sim/limited_sixth_order_diffusion_core_tb.sv */
`timescale 1ns / 1ps
module limited_sixth_order_diffusion_core_tb;
  import ldiff_pkg::*;

  // codes the package leaves unnamed
  localparam logic [1:0] KIND_VERT  = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam logic [1:0] CFG_SPARE  = 2'd3;

  localparam int SMP_MAX = 32'sh7FFF_FFFF;
  localparam int SMP_MIN = 32'sh8000_0000;
  localparam int UNIT    = 65536;          // 1.0 in Q16.16

  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_ITEMS   = 97;
  localparam int SETTLE_CYCLES = 12;       // a little past the nine-stage pipe
  localparam int TAIL_CYCLES   = 20;
  localparam int IDLE_LIMIT    = 4000;     // well past the longest stall or gap pick_gap draws

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  win_t               req;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_rhs_out;

  int fail_count;
  int pending;
  int checked;
  int sent;
  int settings;
  bit calm;      // no random gaps or stalls on either side
  bit flush;     // keep out_ready high while draining

  limited_sixth_order_diffusion_core i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (req.kind),
    .in_sample_minus3    (req.sm3),
    .in_sample_minus2    (req.sm2),
    .in_sample_minus1    (req.sm1),
    .in_sample_center    (req.s0),
    .in_sample_plus1     (req.sp1),
    .in_sample_plus2     (req.sp2),
    .in_sample_plus3     (req.sp3),
    .in_factor_here      (req.fh),
    .in_factor_neighbour (req.fn),
    .in_rhs_in           (req.rhs),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_rhs_out         (out_rhs_out)
  );

  limited_diffusion_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_window   (req),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_rhs_out (out_rhs_out),
    .fail_count  (fail_count),
    .pending     (pending),
    .checked     (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic win_t pack_window(input logic [1:0] kind, input int m3, m2, m1, c,
                                       input int p1, p2, p3,
                                       input logic [15:0] fh, input logic [15:0] fn,
                                       input int rhs);
    win_t w;
    w.kind = kind;
    w.sm3 = m3;
    w.sm2 = m2;
    w.sm1 = m1;
    w.s0 = c;
    w.sp1 = p1;
    w.sp2 = p2;
    w.sp3 = p3;
    w.fh = fh;
    w.fn = fn;
    w.rhs = rhs;
    return w;
  endfunction

  function automatic logic [15:0] random_factor();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      1:       return 16'(16'h4000 + $urandom_range(0, 2047) - 1024);  // near 1.0
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'd1;
      3:       return 32'd1 << 24;
      4:       return $urandom_range(0, 1 << 26);
      default: return $urandom;
    endcase
  endfunction

  // Windows come in several shapes: full-range noise saturates the sum, flat
  // and ramp-like windows stress the flux limiter, narrow noise stays in range.
  function automatic win_t random_window();
    int v[7];
    int base;
    int step;
    int spread;
    int shape;
    int rhs;
    base = $urandom;
    shape = $urandom_range(0, 9);
    step = $urandom_range(0, 1 << 18) - (1 << 17);
    spread = 1 << $urandom_range(1, 22);
    for (int i = 0; i < 7; i++) begin
      if (shape < 3) v[i] = $urandom;
      else if (shape == 3) v[i] = base;
      else if (shape < 7) v[i] = base + i * step + $urandom_range(0, 15) - 8;
      else v[i] = base + $urandom_range(0, spread) - spread / 2;
    end
    case ($urandom_range(0, 3))
      0:       rhs = $urandom;
      1:       rhs = SMP_MAX - $urandom_range(0, 1 << 20);
      2:       rhs = SMP_MIN + $urandom_range(0, 1 << 20);
      default: rhs = $urandom_range(0, 1 << 21) - (1 << 20);
    endcase
    return pack_window(2'($urandom_range(0, 3)), v[0], v[1], v[2], v[3], v[4], v[5], v[6],
                       random_factor(), random_factor(), rhs);
  endfunction

  // Present one request and hold it until accepted. A gap lowers valid first;
  // with hold_for_drain the sender also waits until every result has come back.
  task automatic drive_window(input win_t w, input int gap, input bit hold_for_drain);
    if (hold_for_drain && gap == 0) gap = 1;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      while (hold_for_drain && pending != 0) @(negedge clk);
    end
    in_valid <= 1'b1;
    req <= w;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // Drop valid, wait out every outstanding result and let the pipe settle.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(input logic [31:0] gain, input bit avg_x, input bit avg_y,
                               input bit with_spare);
    wait_idle();
    if (with_spare) write_reg(CFG_SPARE, $urandom);  // unmapped index, must be ignored
    write_reg(CFG_GAIN, gain);
    write_reg(CFG_AVG_X, 32'(avg_x));
    write_reg(CFG_AVG_Y, 32'(avg_y));
    settings++;
  endtask

  // Field extremes, every kind, and the limiter cases: a flux opposing its
  // slope on either face, a zero slope under a nonzero flux, a zero flux on a
  // ramp, and sums that run into both saturation limits.
  task automatic run_directed();
    drive_window(pack_window(KIND_X, 0, 0, 0, 0, 0, 0, 0, 16'h4000, 16'h4000, 0), 0, 1'b0);
    drive_window(pack_window(KIND_Y, SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX,
                             SMP_MAX, 16'hFFFF, 16'hFFFF, SMP_MAX), 0, 1'b0);
    drive_window(pack_window(KIND_X, SMP_MIN, SMP_MAX, SMP_MIN, SMP_MAX, SMP_MIN, SMP_MAX,
                             SMP_MIN, 16'hFFFF, 16'hFFFF, 0), 0, 1'b0);
    drive_window(pack_window(KIND_Y, SMP_MAX, SMP_MIN, SMP_MAX, SMP_MIN, SMP_MAX, SMP_MIN,
                             SMP_MAX, 16'hFFFF, 16'h0000, SMP_MAX), 0, 1'b0);
    drive_window(pack_window(KIND_VERT, SMP_MIN, SMP_MAX, SMP_MIN, SMP_MAX, SMP_MIN, SMP_MAX,
                             SMP_MIN, 16'h0000, 16'h0000, SMP_MIN), 0, 1'b0);
    drive_window(pack_window(KIND_X, 0, 0, 0, UNIT, 100 * UNIT, 0, 0,
                             16'h4000, 16'h8000, 0), 0, 1'b0);
    drive_window(pack_window(KIND_Y, 0, 0, 0, -UNIT, -100 * UNIT, 0, 0,
                             16'h1234, 16'hEDCB, -5 * UNIT), 0, 1'b0);
    drive_window(pack_window(KIND_SPARE, 0, 0, 0, 0, UNIT, 100 * UNIT, 0,
                             16'hFFFF, 16'h0001, 3 * UNIT), 0, 1'b0);
    drive_window(pack_window(KIND_X, -3 * UNIT, -2 * UNIT, -UNIT, 0, UNIT, 2 * UNIT,
                             3 * UNIT, 16'h5555, 16'hAAAA, 12345), 0, 1'b0);
    drive_window(pack_window(KIND_Y, 0, UNIT, 0, 0, 0, UNIT, 0,
                             16'h4000, 16'h2000, 0), 0, 1'b0);
    drive_window(pack_window(KIND_X, 0, 0, 0, 0, 7, 7, 7, 16'hFFFF, 16'hFFFF, SMP_MIN),
                 0, 1'b0);
    drive_window(pack_window(KIND_SPARE, SMP_MAX, 0, SMP_MIN, 0, SMP_MAX, 0, SMP_MIN,
                             16'h0000, 16'h0000, SMP_MAX), 0, 1'b0);
  endtask

  // Result side: random stalls, none while calm or draining.
  initial begin : ready_drive
    int stall;
    stall = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (flush || calm) begin
        out_ready <= 1'b1;
        stall = 0;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  // Abort when neither channel has moved for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("limited_sixth_order_diffusion_core test failed");
    $finish;
  end

  initial begin : stimulus
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_GAIN;
    cfg_wdata = '0;
    in_valid = 1'b0;
    req = '0;
    calm = 1'b0;
    flush = 1'b0;
    sent = 0;
    settings = 1;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // reset values: zero gain, so the rhs passes through untouched
    repeat (2) drive_window(random_window(), pick_gap(), 1'b0);

    // unity gain, x averaged; then full gain, y averaged
    apply_setting(32'd1 << 24, 1'b1, 1'b0, 1'b1);
    run_directed();
    apply_setting(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0);
    run_directed();

    // random phases, each with its own register setting; some run calm,
    // and now and then the sender holds off until the pipe is empty
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      calm = 1'b0;
      if (p == 0) apply_setting(32'd1, 1'b1, 1'b1, 1'b0);
      else if (p == 1) apply_setting(32'd0, 1'b0, 1'b0, 1'b1);
      else apply_setting(pick_gain(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
      calm = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++)
        drive_window(random_window(), calm ? 0 : pick_gap(), $urandom_range(0, 49) == 0);
    end

    calm = 1'b0;
    flush = 1'b1;
    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("sent %0d windows over %0d register settings, %0d results checked",
             sent, settings, checked);
    $display("directed extremes plus random noise, ramp and flat windows, stalls both sides");
    if (fail_count == 0 && pending == 0) begin
      $display("limited_sixth_order_diffusion_core test passed");
    end else begin
      $display("limited_sixth_order_diffusion_core test failed");
    end
    $finish;
  end

endmodule
